// File: rtl/core/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg: shared types and constants of the NMEA sentence validator
// character codes, register indexes, phase type and character class bundle
// ----------------------------------------------------------------------------
`default_nettype none

package nsv_pkg;

  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TILDE  = 8'h7E;

  localparam int unsigned LEN_W      = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] LEN_SLACK = 11'd3;
  localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 10'd82;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_MODE     = 1'b1;

  typedef enum logic [2:0] {
    PH_DOLLAR  = 3'd0,
    PH_BODY    = 3'd1,
    PH_HEX_HI  = 3'd2,
    PH_HEX_LO  = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef struct packed {
    logic       is_dollar;
    logic       is_star;
    logic       printable;
    logic       is_crlf;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_class_t;

endpackage

`default_nettype wire

// File: rtl/core/nmea_sentence_validator.sv
// ----------------------------------------------------------------------------
// nmea_sentence_validator: NMEA 0183 sentence and checksum checker
// one result transaction per sentence, carrying pass flag and body checksum
// ----------------------------------------------------------------------------
// usage
//   in_*  : one sentence character per transaction, in_tlast on its final byte
//   out_* : one transaction per sentence, issued for the byte with in_tlast
//   cfg_* : register writes, index 0 max_body_length, index 1 strict_mode;
//           write only while no sentence is in flight
// timing
//   one byte per cycle; every byte is checked and folded into the sentence
//   state in the cycle it is accepted, so the result appears in out_tdata
//   the cycle after the last byte is taken
//   the single output register decides the rate: while a result waits,
//   in_tready stays high only in cycles where out_tready takes it
// reset
//   rst_n low clears the sentence state and the output valid flag and loads
//   max_body_length = 82, strict_mode = 0
// stall
//   a held result stays stable; input is held off until it drains
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_validator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  wire logic                           in_tlast,   // last_byte
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [15:0]                    out_tdata,  // [0] sentence_valid,
                                                          // [8:1] computed_checksum
  input  wire logic                           cfg_we,
  input  wire logic [nsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nsv_pkg::LEN_W-1:0]      cfg_data
);

  nsv_pkg::phase_t                 phase_r, phase_nxt;
  logic [7:0]                      csum_r, csum_nxt;
  logic [3:0]                      nib_r, nib_nxt;
  logic [nsv_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                            fail_r, fail_nxt;
  logic [nsv_pkg::LEN_W-1:0]       max_len_r;
  logic                            strict_r;
  logic                            out_valid_r;
  logic                            ok_r, ok_nxt;
  logic [7:0]                      out_csum_r;
  logic [nsv_pkg::COUNT_W-1:0]     limit;
  logic                            accept;
  nsv_pkg::char_class_t            cls;

  nsv_char_class u_char_class (
    .chr (in_tdata),
    .cls (cls)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_csum_r, ok_r};
  assign limit      = {1'b0, max_len_r} + nsv_pkg::LEN_SLACK;

  always_comb begin
    phase_nxt = phase_r;
    csum_nxt  = csum_r;
    nib_nxt   = nib_r;
    fail_nxt  = fail_r;
    count_nxt = (count_r != nsv_pkg::COUNT_MAX) ? count_r + 11'd1 : count_r;
    unique case (phase_r)
      nsv_pkg::PH_DOLLAR: begin
        if (cls.is_dollar) begin
          phase_nxt = nsv_pkg::PH_BODY;
        end else begin
          fail_nxt  = 1'b1;
          phase_nxt = nsv_pkg::PH_DISCARD;
        end
      end
      nsv_pkg::PH_BODY: begin
        if (cls.is_star) begin
          phase_nxt = nsv_pkg::PH_HEX_HI;
        end else begin
          if (!cls.printable) fail_nxt = 1'b1;
          csum_nxt = csum_r ^ in_tdata;
        end
      end
      nsv_pkg::PH_HEX_HI: begin
        if (!cls.hex_ok) fail_nxt = 1'b1;
        nib_nxt   = cls.hex_val;
        phase_nxt = nsv_pkg::PH_HEX_LO;
      end
      nsv_pkg::PH_HEX_LO: begin
        if (!cls.hex_ok || {nib_r, cls.hex_val} != csum_r) fail_nxt = 1'b1;
        phase_nxt = nsv_pkg::PH_TRAILER;
      end
      nsv_pkg::PH_TRAILER: begin
        if (!cls.is_crlf) fail_nxt = 1'b1;
      end
      default: begin
        fail_nxt = 1'b1;
      end
    endcase
    ok_nxt = !fail_nxt && (count_nxt <= limit) &&
             ((phase_nxt == nsv_pkg::PH_BODY) ? !strict_r
                                              : (phase_nxt == nsv_pkg::PH_TRAILER));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nsv_pkg::PH_DOLLAR;
      csum_r  <= 8'd0;
      nib_r   <= 4'd0;
      count_r <= '0;
      fail_r  <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        phase_r <= nsv_pkg::PH_DOLLAR;
        csum_r  <= 8'd0;
        nib_r   <= 4'd0;
        count_r <= '0;
        fail_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        csum_r  <= csum_nxt;
        nib_r   <= nib_nxt;
        count_r <= count_nxt;
        fail_r  <= fail_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      ok_r       <= ok_nxt;
      out_csum_r <= csum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= nsv_pkg::MAX_LEN_RESET;
      strict_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsv_pkg::REG_MAX_BODY_LENGTH: max_len_r <= cfg_data;
        nsv_pkg::REG_STRICT_MODE:     strict_r  <= cfg_data[0];
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nsv_char_class.sv
// ----------------------------------------------------------------------------
// nsv_char_class: character classifier
// flags the delimiters, printable range, line ends and decodes hex digits
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_char_class (
  input  wire logic [7:0]          chr,
  output nsv_pkg::char_class_t     cls
);

  always_comb begin
    cls.is_dollar = (chr == nsv_pkg::CHR_DOLLAR);
    cls.is_star   = (chr == nsv_pkg::CHR_STAR);
    cls.printable = (chr >= nsv_pkg::CHR_SPACE) && (chr <= nsv_pkg::CHR_TILDE);
    cls.is_crlf   = (chr == nsv_pkg::CHR_CR) || (chr == nsv_pkg::CHR_LF);
    cls.hex_ok    = 1'b1;
    cls.hex_val   = 4'd0;
    priority if (chr >= 8'h30 && chr <= 8'h39) begin
      cls.hex_val = chr[3:0];
    end else if ((chr >= 8'h41 && chr <= 8'h46) || (chr >= 8'h61 && chr <= 8'h66)) begin
      cls.hex_val = chr[3:0] + 4'd9;
    end else begin
      cls.hex_ok  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nsv_checker.sv
// ----------------------------------------------------------------------------
// nsv_checker: port-level checks for the NMEA sentence validator
// watches both stream channels over time; bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a held result transaction does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result changed");

  // a fresh result only follows an accepted last byte
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) ##1 out_tvalid |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("result without closing byte");

  // an empty output stage never holds off input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("result padding set");

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
